/* hw/rtl/lru_cache_miss_counter_defines.svh */
// Assertion macros for the LRU cache miss counter RTL.
`ifndef LRU_CACHE_MISS_COUNTER_DEFINES_SVH
`define LRU_CACHE_MISS_COUNTER_DEFINES_SVH

// Check a property on every aclk edge outside reset.
`define LCMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every aclk edge, reset included.
`define LCMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* hw/rtl/lcmc_pkg.sv */
// Shared types and constants for the LRU cache miss counter.
package lcmc_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int ADDR_W          = 32;
    localparam int COUNT_W         = 32;
    localparam int CAP_W           = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        ACT_ACCESS = 1'b0,
        ACT_REPORT = 1'b1
    } lcmc_action_t;

    typedef struct packed {
        lcmc_action_t      action;
        logic [ADDR_W-1:0] address;
    } lcmc_in_t;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] miss_count;
    } lcmc_out_t;

    // Recency update request: promote the selected line, and mark a fresh fill.
    typedef struct packed {
        logic promote;
        logic fill;
    } lcmc_rank_cmd_t;

endpackage

/* hw/rtl/lcmc_tag_store.sv */
// Tag registers with one comparator per line.
module lcmc_tag_store #(
    parameter int ENTRIES = lcmc_pkg::ENTRIES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ENTRIES-1:0]          wr_sel,
    input  logic [lcmc_pkg::ADDR_W-1:0] lookup_addr,
    output logic [ENTRIES-1:0]          match_vec
);
    import lcmc_pkg::*;

    logic [ADDR_W-1:0] tag_reg [ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++) begin : g_line
        always_ff @(posedge aclk) begin
            if (wr_en && wr_sel[i]) begin
                tag_reg[i] <= lookup_addr;
            end
        end

        assign match_vec[i] = (tag_reg[i] == lookup_addr);
    end

endmodule

/* hw/rtl/lcmc_recency.sv */
// Per-line recency ranks, LRU line detection and rank promotion.
module lcmc_recency #(
    parameter  int ENTRIES = lcmc_pkg::ENTRIES_DEFAULT,
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int FILL_W  = RANK_W + 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lcmc_pkg::lcmc_rank_cmd_t cmd,
    input  logic [ENTRIES-1:0]       sel_vec,
    input  logic [ENTRIES-1:0]       valid_vec,
    input  logic [FILL_W-1:0]        filled,
    output logic [ENTRIES-1:0]       lru_vec
);
    import lcmc_pkg::*;

    logic [RANK_W-1:0] rank_reg  [ENTRIES];
    logic [RANK_W-1:0] rank_next [ENTRIES];
    logic [RANK_W-1:0] sel_rank;
    logic [FILL_W-1:0] old_rank;
    logic [FILL_W-1:0] oldest_rank;

    // Rank of the selected line; the select is one-hot, so OR the lines.
    always_comb begin
        sel_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sel_vec[i]) begin
                sel_rank = sel_rank | rank_reg[i];
            end
        end
    end

    // A fresh line ranks behind every old line before promotion.
    assign old_rank    = cmd.fill ? filled : {1'b0, sel_rank};
    assign oldest_rank = filled - 1'b1;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_line
        assign lru_vec[i] = valid_vec[i] && ({1'b0, rank_reg[i]} == oldest_rank);

        always_comb begin
            rank_next[i] = rank_reg[i];
            if (cmd.promote) begin
                if (sel_vec[i]) begin
                    rank_next[i] = '0;
                end else if (valid_vec[i] && ({1'b0, rank_reg[i]} < old_rank)) begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rank_reg[i] <= '0;
            end else begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

endmodule

/* hw/rtl/lru_cache_miss_counter.sv */
// Top level of the fully associative LRU cache miss counter.
//
// Fully associative tag store of ENTRIES lines with least-recently-used
// replacement and a saturating 32-bit miss counter. Each input word is either
// an access (action = access, address = tag) or a report (action = report),
// and each yields exactly one result word: hit, and the miss count (after the
// access, or before clearing for a report). The block takes one word per clock
// unless the result register is full and m_ready is low, and passes it through
// one input register, then a stage in which all lines compare their tag in
// parallel and update their rank, then the result register. That parallel
// compare and rank update is what sets the one-word-per-cycle rate. The
// capacity register (reset 16) limits how many lines a miss may fill; values
// above ENTRIES act as ENTRIES, zero makes every access a miss and leaves the
// lines untouched. Lowering capacity drops no line. Write capacity only while
// the block is idle. No clearing pass is needed after reset.
module lru_cache_miss_counter #(
    parameter int ENTRIES = lcmc_pkg::ENTRIES_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [lcmc_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lcmc_pkg::lcmc_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lcmc_pkg::lcmc_out_t        m_data
);
    import lcmc_pkg::*;
    `include "lru_cache_miss_counter_defines.svh"

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = RANK_W + 1;
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    // Configuration and bookkeeping state.
    logic [CAP_W-1:0]   capacity_reg;
    logic [FILL_W-1:0]  filled_reg,     filled_next;
    logic [COUNT_W-1:0] miss_total_reg, miss_total_next;

    // Input register and result register.
    logic      s1_valid_reg, s1_valid_next;
    lcmc_in_t  s1_data_reg;
    logic      m_valid_reg,  m_valid_next;
    lcmc_out_t m_data_reg,   m_data_next;

    logic           advance;
    logic [FILL_W-1:0] cap_eff;
    logic           cap_zero;
    logic           is_access, is_report;
    logic           hit, miss, fill, replace;
    logic [ENTRIES-1:0] valid_vec, raw_match, match_vec, fill_vec, lru_vec, sel_vec;
    lcmc_rank_cmd_t rank_cmd;

    // Move the item on when the result register is free or being drained.
    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Clamp capacity to the number of physical lines.
    always_comb begin
        if (CMP_W'(capacity_reg) > CMP_W'(ENTRIES)) begin
            cap_eff = FILL_W'(ENTRIES);
        end else begin
            cap_eff = FILL_W'(capacity_reg);
        end
    end
    assign cap_zero = (cap_eff == '0);

    for (genvar i = 0; i < ENTRIES; i++) begin : g_line
        assign valid_vec[i] = (FILL_W'(i) < filled_reg);
        assign fill_vec[i]  = (FILL_W'(i) == filled_reg);
    end

    // Only filled lines may hit; stored tags are unique, so at most one does.
    assign match_vec = raw_match & valid_vec;

    assign is_access = advance && (s1_data_reg.action == ACT_ACCESS);
    assign is_report = advance && (s1_data_reg.action == ACT_REPORT);
    assign hit       = is_access && !cap_zero && (|match_vec);
    assign miss      = is_access && !hit;
    assign fill      = miss && !cap_zero && (filled_reg < cap_eff);
    assign replace   = miss && !cap_zero && !fill;

    // Pick the line to promote: the hit line, the next free line, or the LRU line.
    always_comb begin
        if (hit) begin
            sel_vec = match_vec;
        end else if (fill) begin
            sel_vec = fill_vec;
        end else begin
            sel_vec = lru_vec;
        end
    end

    assign rank_cmd.promote = hit || fill || replace;
    assign rank_cmd.fill    = fill;

    lcmc_tag_store #(
        .ENTRIES (ENTRIES)
    ) u_tag_store (
        .aclk        (aclk),
        .wr_en       (fill || replace),
        .wr_sel      (sel_vec),
        .lookup_addr (s1_data_reg.address),
        .match_vec   (raw_match)
    );

    lcmc_recency #(
        .ENTRIES (ENTRIES)
    ) u_recency (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (rank_cmd),
        .sel_vec   (sel_vec),
        .valid_vec (valid_vec),
        .filled    (filled_reg),
        .lru_vec   (lru_vec)
    );

    // Advance the fill level, count misses with saturation, clear on report, and build the result word.
    always_comb begin
        filled_next     = filled_reg;
        miss_total_next = miss_total_reg;
        m_data_next     = m_data_reg;
        if (fill) begin
            filled_next = filled_reg + 1'b1;
        end
        if (is_report) begin
            miss_total_next = '0;
        end else if (miss && (miss_total_reg != '1)) begin
            miss_total_next = miss_total_reg + 1'b1;
        end
        if (advance) begin
            m_data_next.hit        = hit;
            m_data_next.miss_count = is_report ? miss_total_reg : miss_total_next;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_valid && s_ready) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= CAP_RESET;
            filled_reg     <= '0;
            miss_total_reg <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            filled_reg     <= filled_next;
            miss_total_reg <= miss_total_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers: hold unless a new word moves in.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_data_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    `LCMC_ASSERT(a_match_unique, $onehot0(match_vec), "two filled lines hold the same tag")
    `LCMC_ASSERT(a_lru_single, replace |-> $onehot(lru_vec), "no single LRU line at replacement")
    `LCMC_ASSERT(a_filled_bound, filled_reg <= FILL_W'(ENTRIES), "fill count past line count")
    `LCMC_ASSERT(a_report_clears, is_report |=> (miss_total_reg == '0), "report left the count set")

endmodule

/* tb/tb_lru_cache_miss_counter.sv */
// Self-checking testbench for the LRU cache miss counter top level.
module tb_lru_cache_miss_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import lcmc_pkg::*;

    localparam int LINES       = ENTRIES_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;
    localparam int POOL_MAX    = 32;

    // Clock, reset and DUT ports; every input starts at a known value.
    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    lcmc_in_t         s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    lcmc_out_t        m_data;

    // Prediction state: tags, recency ranks (0 = most recent), fill level,
    // miss total and the capacity register as last written.
    logic [ADDR_W-1:0]  pred_tag  [LINES];
    int unsigned        pred_rank [LINES];
    int unsigned        pred_used;
    logic [COUNT_W-1:0] pred_misses;
    int unsigned        pred_cap;

    // Result words still owed by the DUT, oldest first.
    lcmc_out_t expected_q[$];

    // Bookkeeping for checks and the closing summary.
    int error_count   = 0;
    int cycle_count   = 0;
    int access_count  = 0;
    int hit_count     = 0;
    int report_count  = 0;

    // Knobs shared between the test tasks and the channel processes.
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    int hold_request = 0;
    int hold_left    = 0;

    // Address pool for the random part: reuse drives hits, size drives evictions.
    logic [ADDR_W-1:0] addr_pool [POOL_MAX];
    int                pool_size = 1;

    lru_cache_miss_counter #(
        .ENTRIES(LINES)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run; the limit is far above the slowest legal run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_q.size());
            $display("tb_lru_cache_miss_counter NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // LRU prediction
    // ------------------------------------------------------------------

    function automatic void clear_prediction();
        for (int i = 0; i < LINES; i++) begin
            pred_tag[i]  = '0;
            pred_rank[i] = 0;
        end
        pred_used   = 0;
        pred_misses = '0;
        pred_cap    = 32'(CAP_RESET);
    endfunction

    // Saturate at all ones rather than wrap.
    function automatic void bump_misses();
        if (pred_misses != {COUNT_W{1'b1}})
            pred_misses = pred_misses + 1'b1;
    endfunction

    // Make line idx the most recent; lines newer than old_rank age by one.
    function automatic void promote_line(int unsigned idx, int unsigned old_rank);
        for (int unsigned i = 0; i < pred_used; i++) begin
            if (pred_rank[i] < old_rank)
                pred_rank[i]++;
        end
        pred_rank[idx] = 0;
    endfunction

    function automatic lcmc_out_t lru_lookup(lcmc_in_t word);
        lcmc_out_t   res;
        int unsigned eff_cap;
        int unsigned victim;
        int unsigned worst;
        res.hit = 1'b0;

        // Report: hand back the count before clearing it.
        if (word.action == ACT_REPORT) begin
            res.miss_count = pred_misses;
            pred_misses    = '0;
            return res;
        end

        eff_cap = (pred_cap > LINES) ? LINES : pred_cap;

        // Zero capacity: count the miss, leave tags and ranks alone.
        if (eff_cap == 0) begin
            bump_misses();
            res.miss_count = pred_misses;
            return res;
        end

        // Any filled line may hit, even above a lowered capacity.
        for (int unsigned i = 0; i < pred_used; i++) begin
            if (pred_tag[i] == word.address) begin
                promote_line(i, pred_rank[i]);
                res.hit        = 1'b1;
                res.miss_count = pred_misses;
                return res;
            end
        end

        bump_misses();
        if (pred_used < eff_cap) begin
            // Fresh line ranks behind all older lines, then moves to the front.
            victim = pred_used;
            pred_used++;
            pred_tag[victim]  = word.address;
            pred_rank[victim] = pred_used - 1;
            promote_line(victim, pred_used - 1);
        end else begin
            // Evict the least recent of all filled lines.
            victim = 0;
            worst  = 0;
            for (int unsigned i = 0; i < pred_used; i++) begin
                if (pred_rank[i] >= worst) begin
                    worst  = pred_rank[i];
                    victim = i;
                end
            end
            pred_tag[victim] = word.address;
            promote_line(victim, worst);
        end
        res.miss_count = pred_misses;
        return res;
    endfunction

    function automatic void flag_mismatch(string what, logic [COUNT_W-1:0] exp_val,
                                          logic [COUNT_W-1:0] got_val);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("Mismatch at cycle %0d on %s: expected 0x%08h, got 0x%08h",
                     cycle_count, what, exp_val, got_val);
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on input acceptance, compare on output acceptance.
    // Input side goes first so a result's entry is queued before it is compared.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        lcmc_out_t want;
        if (aresetn) begin
            // Capacity write lands at the same edge as in the DUT.
            if (cfg_wr_en)
                pred_cap = 32'(cfg_wr_data);

            if (s_valid && s_ready) begin
                if (s_data.action == ACT_REPORT)
                    report_count++;
                else
                    access_count++;
                expected_q = {expected_q, lru_lookup(s_data)};
            end

            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("Unexpected result word at cycle %0d: hit %0b count 0x%08h",
                                 cycle_count, m_data.hit, m_data.miss_count);
                end else begin
                    want = expected_q.pop_front();
                    if (want.hit)
                        hit_count++;
                    if (m_data.hit !== want.hit)
                        flag_mismatch("hit", COUNT_W'(want.hit), COUNT_W'(m_data.hit));
                    if (m_data.miss_count !== want.miss_count)
                        flag_mismatch("miss_count", want.miss_count, m_data.miss_count);
                end
            end
        end
    end

    // Result side: random stalls, or a counted hold-off when a test asks.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !rx_idle_on || ($urandom_range(99) >= 10);
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus helpers
    // ------------------------------------------------------------------

    // Offer one word, maybe after a random gap; return at its acceptance edge.
    task automatic send_word(input lcmc_in_t word);
        while (tx_idle_on && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    task automatic send_access(input logic [ADDR_W-1:0] addr);
        lcmc_in_t word;
        word.action  = ACT_ACCESS;
        word.address = addr;
        send_word(word);
    endtask

    task automatic send_report();
        lcmc_in_t word;
        word.action  = ACT_REPORT;
        word.address = $urandom;  // ignored by the block, toggles the bits anyway
        send_word(word);
    endtask

    // Drop valid and hold until every owed result word has come back.
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0)
            @(posedge aclk);
    endtask

    // Write capacity only with the pipeline empty.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drain();
        cfg_wr_data <= cap;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Fresh random tags; sometimes seed the all-zeros and all-ones tags.
    task automatic refill_pool(input int size);
        pool_size = size;
        for (int i = 0; i < size; i++)
            addr_pool[i] = $urandom;
        if ($urandom_range(3) == 0)
            addr_pool[0] = '0;
        if ($urandom_range(3) == 0)
            addr_pool[size-1] = '1;
    endtask

    // Mostly pool reuse, a few cold addresses and occasional reports.
    task automatic send_random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            send_report();
        else if (pick < 20)
            send_access($urandom);
        else
            send_access(addr_pool[$urandom_range(pool_size - 1)]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built sequences: reset capacity, hits, LRU eviction order,
    // capacity zero, capacity above the line count, and shrinking capacity.
    task automatic test_directed();
        // Reset capacity: two misses, a hit, then report and an empty report.
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);
        send_report();
        send_report();

        // Two lines: stored lines survive the write, then LRU eviction order.
        set_capacity(5'd2);
        send_access(32'h0000_0000);
        send_access(32'h1234_5678);
        send_access(32'hFFFF_FFFF);
        send_access(32'h1234_5678);
        send_access(32'h0000_0000);
        send_report();

        // Zero capacity: every access misses, even for a stored tag.
        set_capacity(5'd0);
        send_access(32'h1234_5678);
        send_access(32'h0000_0000);
        send_report();

        // Above the line count: acts as a full table.
        set_capacity(5'd31);
        send_access(32'h0000_0000);
        send_access(32'hAAAA_AAAA);
        send_access(32'h5555_5555);
        send_access(32'h5555_5555);
        send_report();

        // Capacity below the fill level: hits on any line, misses replace.
        set_capacity(5'd1);
        send_access(32'h0000_0000);
        send_access(32'h8765_4321);
        send_access(32'h1234_5678);
        send_report();
    endtask

    // Random traffic under a spread of capacities, both sides idling.
    task automatic test_capacity_sweep();
        logic [CAP_W-1:0] caps [10] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd4,
                                        5'd8, 5'd3, 5'd12, 5'd20, 5'd16};
        for (int p = 0; p < 10; p++) begin
            set_capacity(caps[p]);
            refill_pool($urandom_range(2, 24));
            repeat (150)
                send_random_word();
        end
    endtask

    // Receiver holds off for a long stretch while words keep coming, so the
    // block fills and stalls its input; then pause until all results return.
    task automatic test_backpressure();
        set_capacity(5'd8);
        refill_pool(12);
        tx_idle_on   = 1'b0;
        hold_request = 300;
        repeat (200)
            send_random_word();
        tx_idle_on = 1'b1;
        wait_drain();
    endtask

    // Long stretch with no idling on either side.
    task automatic test_streaming();
        set_capacity(5'd16);
        refill_pool(20);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (250)
            send_random_word();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        clear_prediction();
        repeat (11)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_capacity_sweep();
        test_backpressure();
        test_streaming();

        // Let the tail drain, then wait a little longer for stray words.
        wait_drain();
        repeat (10)
            @(posedge aclk);
        if (expected_q.size() != 0) begin
            error_count++;
            $display("%0d result words never arrived", expected_q.size());
        end

        $display("Covered %0d accesses (%0d hits) and %0d reports in %0d cycles,",
                 access_count, hit_count, report_count, cycle_count);
        $display("capacities 0 to 31 incl. shrink below fill, long output hold-off; %0d errors",
                 error_count);
        if (error_count == 0) begin
            $display("tb_lru_cache_miss_counter OK");
        end else begin
            $display("tb_lru_cache_miss_counter NOT OK");
        end
        $finish;
    end

endmodule
